/* hdl/display_list_primitive_assembler_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the display list primitive assembler
// Shorthand for the implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_LIST_PRIMITIVE_ASSEMBLER_MACROS_SVH
`define DISPLAY_LIST_PRIMITIVE_ASSEMBLER_MACROS_SVH

// Same-cycle implication, disabled while rst is high
`define DLPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dlpa check failed: same-cycle implication");

// Next-cycle implication, disabled while rst is high
`define DLPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dlpa check failed: next-cycle implication");

`endif

/* hdl/dlpa_pkg.sv */
// ----------------------------------------------------------------------------
// dlpa_pkg
// Types and constants shared by the display list primitive assembler.
// ----------------------------------------------------------------------------
package dlpa_pkg;

   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned ATTR_WIDTH   = 16;
   localparam int unsigned CORNER_WIDTH = 64;
   localparam int unsigned SLOT_WIDTH   = 2;
   localparam int unsigned CFG_WIDTH    = 3;
   localparam int unsigned KIND_WIDTH   = 2;
   localparam int unsigned COUNT_WIDTH  = 16;

   // primitive opcodes
   localparam logic [BYTE_WIDTH-1:0] OP_NOP   = 8'h00;
   localparam logic [BYTE_WIDTH-1:0] OP_LIST  = 8'h90;
   localparam logic [BYTE_WIDTH-1:0] OP_STRIP = 8'h98;
   localparam logic [BYTE_WIDTH-1:0] OP_FAN   = 8'hA0;

   // source primitive kinds on the result
   localparam logic [KIND_WIDTH-1:0] KIND_LIST  = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_STRIP = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_FAN   = 2'd2;

   // one display list byte
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  list_end;
   } item_type;

   // one assembled triangle
   typedef struct packed {
      logic [CORNER_WIDTH-1:0] corner_third;
      logic [CORNER_WIDTH-1:0] corner_second;
      logic [CORNER_WIDTH-1:0] corner_first;
      logic [KIND_WIDTH-1:0]   prim_kind;
   } tri_type;

endpackage

/* hdl/dlpa_in_stage.sv */
// ----------------------------------------------------------------------------
// dlpa_in_stage
// Input register with a skid entry, so that req_tready comes from a flop.
// ----------------------------------------------------------------------------
module dlpa_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] data_byte
   input  logic              req_tlast,   // list_end
   output logic              item_valid,
   output dlpa_pkg::item_type item,
   input  logic              item_take
);

   logic               main_valid_ff, main_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   dlpa_pkg::item_type main_ff, main_in;
   dlpa_pkg::item_type skid_ff, skid_in;
   dlpa_pkg::item_type word;
   logic               accept;

   assign word.data_byte = req_tdata;
   assign word.list_end  = req_tlast;
   assign req_tready     = ~skid_valid_ff;
   assign accept         = req_tvalid & req_tready;
   assign item_valid     = main_valid_ff;
   assign item           = main_ff;

   // refill the main register from the skid entry or the port
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (item_take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = word;
            main_valid_in = accept;
         end
      end else if (accept) begin
         if (main_valid_ff) begin
            skid_in       = word;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = word;
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

/* hdl/dlpa_parse.sv */
// ----------------------------------------------------------------------------
// dlpa_parse
// Display list parser state and triangle assembly, one byte per step.
// ----------------------------------------------------------------------------
module dlpa_parse #(
   parameter int unsigned MAX_ATTRS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  dlpa_pkg::item_type               item,
   input  logic [dlpa_pkg::CFG_WIDTH-1:0]   attr_count,
   output logic                             emit,
   output dlpa_pkg::tri_type                result
);

   localparam int unsigned VW = dlpa_pkg::ATTR_WIDTH * MAX_ATTRS;

   typedef enum logic [2:0] {
      PH_OPCODE   = 3'd0,
      PH_COUNT_HI = 3'd1,
      PH_COUNT_LO = 3'd2,
      PH_ATTR_HI  = 3'd3,
      PH_ATTR_LO  = 3'd4
   } phase_type;

   phase_type                            phase_ff, phase_in;
   logic [dlpa_pkg::BYTE_WIDTH-1:0]      opcode_ff, opcode_in;
   logic [dlpa_pkg::BYTE_WIDTH-1:0]      high_ff, high_in;
   logic [dlpa_pkg::COUNT_WIDTH-1:0]     left_ff, left_in;
   logic [1:0]                           pos_ff, pos_in;      // vertex position, stops at 2
   logic [1:0]                           mod3_ff, mod3_in;    // vertex position mod 3
   logic                                 odd_ff, odd_in;      // vertex position is odd
   logic [dlpa_pkg::SLOT_WIDTH-1:0]      slot_ff, slot_in;
   logic [VW-1:0]                        build_ff, build_in;
   logic [VW-1:0]                        prev_ff, prev_in;
   logic [VW-1:0]                        prev2_ff, prev2_in;
   logic [VW-1:0]                        pivot_ff, pivot_in;

   logic [dlpa_pkg::CFG_WIDTH-1:0]       eff_attrs;
   logic [dlpa_pkg::ATTR_WIDTH-1:0]      pair;
   logic [dlpa_pkg::COUNT_WIDTH-1:0]     count;
   logic [VW-1:0]                        merged;
   logic [dlpa_pkg::CFG_WIDTH-1:0]       slot_next;

   assign pair      = {high_ff, item.data_byte};
   assign count     = pair;
   assign slot_next = dlpa_pkg::CFG_WIDTH'(slot_ff) + dlpa_pkg::CFG_WIDTH'(1);

   // clamp the attribute count into 1..MAX_ATTRS
   always_comb begin
      priority if (attr_count == '0) begin
         eff_attrs = dlpa_pkg::CFG_WIDTH'(1);
      end else if (attr_count > dlpa_pkg::CFG_WIDTH'(MAX_ATTRS)) begin
         eff_attrs = dlpa_pkg::CFG_WIDTH'(MAX_ATTRS);
      end else begin
         eff_attrs = attr_count;
      end
   end

   // drop the new index into its lane of the vertex word
   always_comb begin
      for (int k = 0; k < MAX_ATTRS; k++) begin
         merged[k*dlpa_pkg::ATTR_WIDTH +: dlpa_pkg::ATTR_WIDTH] =
            (slot_ff == dlpa_pkg::SLOT_WIDTH'(k)) ? pair
            : build_ff[k*dlpa_pkg::ATTR_WIDTH +: dlpa_pkg::ATTR_WIDTH];
      end
   end

   // next parser state and triangle for this byte
   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      high_in   = high_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      mod3_in   = mod3_ff;
      odd_in    = odd_ff;
      slot_in   = slot_ff;
      build_in  = build_ff;
      prev_in   = prev_ff;
      prev2_in  = prev2_ff;
      pivot_in  = pivot_ff;
      emit      = 1'b0;
      result    = '0;
      unique case (phase_ff)
         PH_COUNT_HI: begin
            high_in  = item.data_byte;
            phase_in = PH_COUNT_LO;
         end
         PH_COUNT_LO: begin
            left_in  = count;
            pos_in   = '0;
            mod3_in  = '0;
            odd_in   = 1'b0;
            slot_in  = '0;
            build_in = '0;
            phase_in = (count == '0) ? PH_OPCODE : PH_ATTR_HI;
         end
         PH_ATTR_HI: begin
            high_in  = item.data_byte;
            phase_in = PH_ATTR_LO;
         end
         PH_ATTR_LO: begin
            if (slot_next >= eff_attrs) begin
               // vertex complete: emit by primitive kind, then shift history
               result.corner_third = dlpa_pkg::CORNER_WIDTH'(merged);
               unique case (opcode_ff)
                  dlpa_pkg::OP_LIST: begin
                     emit                 = (mod3_ff == 2'd2);
                     result.corner_first  = dlpa_pkg::CORNER_WIDTH'(prev2_ff);
                     result.corner_second = dlpa_pkg::CORNER_WIDTH'(prev_ff);
                     result.prim_kind     = dlpa_pkg::KIND_LIST;
                  end
                  dlpa_pkg::OP_STRIP: begin
                     emit = (pos_ff == 2'd2);
                     if (odd_ff) begin
                        result.corner_first  = dlpa_pkg::CORNER_WIDTH'(prev_ff);
                        result.corner_second = dlpa_pkg::CORNER_WIDTH'(prev2_ff);
                     end else begin
                        result.corner_first  = dlpa_pkg::CORNER_WIDTH'(prev2_ff);
                        result.corner_second = dlpa_pkg::CORNER_WIDTH'(prev_ff);
                     end
                     result.prim_kind = dlpa_pkg::KIND_STRIP;
                  end
                  dlpa_pkg::OP_FAN: begin
                     emit                 = (pos_ff == 2'd2);
                     result.corner_first  = dlpa_pkg::CORNER_WIDTH'(pivot_ff);
                     result.corner_second = dlpa_pkg::CORNER_WIDTH'(prev_ff);
                     result.prim_kind     = dlpa_pkg::KIND_FAN;
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
               if (pos_ff == 2'd0) begin
                  pivot_in = merged;
               end
               prev2_in = prev_ff;
               prev_in  = merged;
               pos_in   = (pos_ff == 2'd2) ? 2'd2 : pos_ff + 2'd1;
               mod3_in  = (mod3_ff == 2'd2) ? 2'd0 : mod3_ff + 2'd1;
               odd_in   = ~odd_ff;
               left_in  = left_ff - dlpa_pkg::COUNT_WIDTH'(1);
               slot_in  = '0;
               build_in = '0;
               phase_in = (left_ff == dlpa_pkg::COUNT_WIDTH'(1)) ? PH_OPCODE : PH_ATTR_HI;
            end else begin
               slot_in  = dlpa_pkg::SLOT_WIDTH'(slot_next);
               build_in = merged;
               phase_in = PH_ATTR_HI;
            end
         end
         default: begin
            if (item.data_byte != dlpa_pkg::OP_NOP) begin
               opcode_in = item.data_byte;
               phase_in  = PH_COUNT_HI;
            end else begin
               phase_in  = PH_OPCODE;
            end
         end
      endcase
      // end of list: return the parser to its idle state
      if (item.list_end) begin
         phase_in  = PH_OPCODE;
         opcode_in = '0;
         high_in   = '0;
         left_in   = '0;
         pos_in    = '0;
         mod3_in   = '0;
         odd_in    = 1'b0;
         slot_in   = '0;
         build_in  = '0;
         prev_in   = '0;
         prev2_in  = '0;
         pivot_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPCODE;
         opcode_ff <= '0;
         high_ff   <= '0;
         left_ff   <= '0;
         pos_ff    <= '0;
         mod3_ff   <= '0;
         odd_ff    <= 1'b0;
         slot_ff   <= '0;
         build_ff  <= '0;
         prev_ff   <= '0;
         prev2_ff  <= '0;
         pivot_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         high_ff   <= high_in;
         left_ff   <= left_in;
         pos_ff    <= pos_in;
         mod3_ff   <= mod3_in;
         odd_ff    <= odd_in;
         slot_ff   <= slot_in;
         build_ff  <= build_in;
         prev_ff   <= prev_in;
         prev2_ff  <= prev2_in;
         pivot_ff  <= pivot_in;
      end
   end

endmodule

/* hdl/dlpa_out_stage.sv */
// ----------------------------------------------------------------------------
// dlpa_out_stage
// Result register for one triangle, drained by the rsp stream.
// ----------------------------------------------------------------------------
module dlpa_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               emit,
   input  dlpa_pkg::tri_type  result,
   output logic               core_ready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [191:0]       rsp_tdata,  // [63:0] corner_first, [127:64] corner_second,
                                          // [191:128] corner_third
   output logic [1:0]         rsp_tuser   // prim_kind
);

   logic              valid_ff, valid_in;
   dlpa_pkg::tri_type tri_ff;

   // the core may step when the register is empty or is being drained
   assign core_ready = ~valid_ff | rsp_tready;
   assign valid_in   = core_ready ? (step & emit) : valid_ff;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {tri_ff.corner_third, tri_ff.corner_second, tri_ff.corner_first};
   assign rsp_tuser  = tri_ff.prim_kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (core_ready & step & emit) begin
         tri_ff <= result;
      end
   end

endmodule

/* hdl/display_list_primitive_assembler.sv */
// ----------------------------------------------------------------------------
// display_list_primitive_assembler
// Turns a byte stream of display list commands into triangles.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one display list byte per word; req_tlast marks the last byte of
//            a list, after which the parser returns to its idle state.
//   rsp_*  : one triangle per word, three 64-bit corners in rsp_tdata and the
//            source primitive kind (list, strip, fan) in rsp_tuser.
//   csr_*  : attribute indices per vertex; write only while no list is open.
// Throughput is one byte per cycle while no triangle stalls in the result
// register: the parser does a single state update per byte between the input
// register and the result register, from which each triangle goes out on rsp.
// req_tready comes from a flop. The parser halts while a triangle waits in
// the result register with rsp_tready low; the input register and a skid
// entry then take at most two more bytes before req_tready falls.
// A stalled result holds its word until taken.
// Reset (synchronous) empties the input, skid and result registers, returns
// the parser to the opcode phase and sets the attribute count to one.
// ----------------------------------------------------------------------------
module display_list_primitive_assembler #(
   parameter int unsigned MAX_ATTRS = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // list_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // [63:0] corner_first, [127:64] corner_second,
                                     // [191:128] corner_third
   output logic [1:0]   rsp_tuser,   // prim_kind
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_data     // attr_count
);

   logic                            item_valid;
   dlpa_pkg::item_type              item;
   logic                            core_ready;
   logic                            step;
   logic                            emit;
   dlpa_pkg::tri_type               result;
   logic [dlpa_pkg::CFG_WIDTH-1:0]  attr_count_ff;

   assign csr_ready = 1'b1;
   assign step      = item_valid & core_ready;

   // hold the attribute count register
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_count_ff <= dlpa_pkg::CFG_WIDTH'(1);
      end else if (csr_valid & csr_ready) begin
         attr_count_ff <= csr_data;
      end
   end

   dlpa_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (step)
   );

   dlpa_parse #(
      .MAX_ATTRS (MAX_ATTRS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (item),
      .attr_count (attr_count_ff),
      .emit       (emit),
      .result     (result)
   );

   dlpa_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .emit       (emit),
      .result     (result),
      .core_ready (core_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* hdl/dlpa_checker.sv */
// ----------------------------------------------------------------------------
// dlpa_checker
// Port-level checks on the primitive assembler, bound to the top level.
// ----------------------------------------------------------------------------
`include "display_list_primitive_assembler_macros.svh"

module dlpa_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [191:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // a stalled triangle keeps its word
   `DLPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // reset empties the result register
   `DLPA_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid && req_tready)

   // only list, strip and fan kinds leave the block
   `DLPA_ASSERT_NOW(a_kind_legal, clock, reset, rsp_tvalid, rsp_tuser == dlpa_pkg::KIND_LIST || rsp_tuser == dlpa_pkg::KIND_STRIP || rsp_tuser == dlpa_pkg::KIND_FAN)

   // a result never rises on rsp straight out of reset
   `DLPA_ASSERT_NOW(a_rsp_cause, clock, reset, $rose(rsp_tvalid), !$past(reset))

endmodule

bind display_list_primitive_assembler dlpa_checker u_checker (.*);

/* tb/tb_display_list_primitive_assembler.sv */
// ----------------------------------------------------------------------------
// tb_display_list_primitive_assembler
// Self-checking bench for the display list primitive assembler. A predictor
// class tracks the parser over every accepted byte and queues the triangles
// it expects; each triangle taken from rsp is checked against the oldest
// one. Stimulus is a few directed lists, then random display lists (complete,
// cut off and noise) under several attribute counts, with bursty input and
// a varying stall pattern on the result side.
// ----------------------------------------------------------------------------

typedef enum logic [2:0] {
   EXPECT_OPCODE,
   EXPECT_COUNT_HI,
   EXPECT_COUNT_LO,
   EXPECT_ATTR_HI,
   EXPECT_ATTR_LO
} parse_phase_type;

typedef enum int {
   DRAIN_FREE,
   DRAIN_COIN,
   DRAIN_MOSTLY,
   DRAIN_BURSTY
} drain_mode_type;

class triangle_predictor;
   localparam int unsigned ATTR_LIMIT = 4;

   logic [2:0]         attr_reg;
   parse_phase_type    phase;
   logic [7:0]         opcode;
   logic [7:0]         high_byte;
   logic [15:0]        verts_left;
   logic [15:0]        vert_pos;
   logic [1:0]         slot;
   logic [63:0]        build;
   logic [63:0]        prev_vert;
   logic [63:0]        prev_prev_vert;
   logic [63:0]        pivot_vert;
   dlpa_pkg::tri_type  expected_tris[$];
   int                 mismatches;

   function new();
      attr_reg   = 3'd1;
      mismatches = 0;
      clear();
   endfunction

   function void clear();
      phase          = EXPECT_OPCODE;
      opcode         = '0;
      high_byte      = '0;
      verts_left     = '0;
      vert_pos       = '0;
      slot           = '0;
      build          = '0;
      prev_vert      = '0;
      prev_prev_vert = '0;
      pivot_vert     = '0;
   endfunction

   // clamp the register to 1..ATTR_LIMIT
   function int attrs_in_use();
      if (attr_reg == 3'd0) return 1;
      if (attr_reg > ATTR_LIMIT) return ATTR_LIMIT;
      return attr_reg;
   endfunction

   // shift the finished vertex into history, queue a triangle if one closes
   function void close_vertex(logic [63:0] v);
      dlpa_pkg::tri_type t;
      logic              emit;
      emit = 1'b0;
      t.corner_third = v;
      if (opcode == dlpa_pkg::OP_LIST) begin
         if ((vert_pos % 3) == 2) begin
            t.corner_first  = prev_prev_vert;
            t.corner_second = prev_vert;
            t.prim_kind     = dlpa_pkg::KIND_LIST;
            emit            = 1'b1;
         end
      end else if (opcode == dlpa_pkg::OP_STRIP) begin
         if (vert_pos >= 2) begin
            // odd positions swap the first two corners to keep the winding
            t.corner_first  = vert_pos[0] ? prev_vert : prev_prev_vert;
            t.corner_second = vert_pos[0] ? prev_prev_vert : prev_vert;
            t.prim_kind     = dlpa_pkg::KIND_STRIP;
            emit            = 1'b1;
         end
      end else if (opcode == dlpa_pkg::OP_FAN) begin
         if (vert_pos >= 2) begin
            t.corner_first  = pivot_vert;
            t.corner_second = prev_vert;
            t.prim_kind     = dlpa_pkg::KIND_FAN;
            emit            = 1'b1;
         end
      end
      if (emit) expected_tris.insert(expected_tris.size(), t);
      if (vert_pos == 16'd0) pivot_vert = v;
      prev_prev_vert = prev_vert;
      prev_vert      = v;
      vert_pos       = vert_pos + 16'd1;
      verts_left     = verts_left - 16'd1;
      slot           = '0;
      build          = '0;
      phase          = (verts_left == 16'd0) ? EXPECT_OPCODE : EXPECT_ATTR_HI;
   endfunction

   // advance the parser by one accepted byte
   function void note_byte(logic [7:0] b, logic last);
      logic [15:0] idx;
      case (phase)
         EXPECT_COUNT_HI: begin
            high_byte = b;
            phase     = EXPECT_COUNT_LO;
         end
         EXPECT_COUNT_LO: begin
            verts_left = {high_byte, b};
            vert_pos   = '0;
            slot       = '0;
            build      = '0;
            phase      = (verts_left == 16'd0) ? EXPECT_OPCODE : EXPECT_ATTR_HI;
         end
         EXPECT_ATTR_HI: begin
            high_byte = b;
            phase     = EXPECT_ATTR_LO;
         end
         EXPECT_ATTR_LO: begin
            idx   = {high_byte, b};
            build = build | (64'(idx) << (16 * slot));
            if (int'(slot) + 1 >= attrs_in_use()) begin
               close_vertex(build);
            end else begin
               slot  = slot + 2'd1;
               phase = EXPECT_ATTR_HI;
            end
         end
         default: begin
            if (b != dlpa_pkg::OP_NOP) begin
               opcode = b;
               phase  = EXPECT_COUNT_HI;
            end else begin
               phase = EXPECT_OPCODE;
            end
         end
      endcase
      if (last) clear();
   endfunction

   function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
         $error("%s: expected %h, got %h", name, exp, act);
         mismatches++;
      end
   endfunction

   // check one triangle taken from rsp against the oldest expectation
   function void check_triangle(logic [191:0] tdata, logic [1:0] tuser);
      dlpa_pkg::tri_type t;
      if (expected_tris.size() == 0) begin
         $error("unexpected triangle: tdata %h, tuser %h", tdata, tuser);
         mismatches++;
         return;
      end
      t = expected_tris.pop_front();
      compare_field("corner_first", t.corner_first, tdata[63:0]);
      compare_field("corner_second", t.corner_second, tdata[127:64]);
      compare_field("corner_third", t.corner_third, tdata[191:128]);
      compare_field("prim_kind", 64'(t.prim_kind), 64'(tuser));
   endfunction

   function int pending();
      return expected_tris.size();
   endfunction
endclass

module tb_display_list_primitive_assembler;

   localparam int NUM_PHASES      = 12;
   localparam int BYTES_PER_PHASE = 60;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_LIMIT     = 200000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [191:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_data = '0;

   triangle_predictor tri_model;
   logic [7:0]        list_bytes[$];
   int                burst_left = 0;
   drain_mode_type    drain_mode = DRAIN_FREE;
   int                mode_left = 0;
   int                stall_left = 0;

   display_list_primitive_assembler #(
      .MAX_ATTRS(4)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // check every triangle word taken from rsp
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tri_model.check_triangle(rsp_tdata, rsp_tuser);
   end

   // stall the result side on one of four drain patterns, picked anew at random
   always @(negedge clock) begin
      logic rdy;
      if (mode_left == 0) begin
         drain_mode = drain_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(40, 300);
      end
      mode_left--;
      case (drain_mode)
         DRAIN_FREE:   rdy = 1'b1;
         DRAIN_COIN:   rdy = 1'($urandom_range(0, 1));
         DRAIN_MOSTLY: rdy = ($urandom_range(0, 7) != 0);
         default: begin
            if (stall_left > 0) begin
               rdy = 1'b0;
               stall_left--;
            end else if ($urandom_range(0, 9) == 0) begin
               rdy        = 1'b0;
               stall_left = $urandom_range(5, 25);
            end else begin
               rdy = 1'b1;
            end
         end
      endcase
      rsp_tready <= rdy;
   end

   // send one byte; entered and left at a falling edge
   task automatic push_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         repeat (gap) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      tri_model.note_byte(b, last);
      burst_left--;
      @(negedge clock);
   endtask

   // send the built list, marking its final byte as the end of the list
   task automatic send_list();
      foreach (list_bytes[i]) push_byte(list_bytes[i], i == list_bytes.size() - 1);
   endtask

   // hold off until every triangle is back and the parser has gone quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (tri_model.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_attrs(input logic [2:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      tri_model.attr_reg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_index();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // append one byte to the list under construction
   function automatic void add_byte(input logic [7:0] b);
      list_bytes.insert(list_bytes.size(), b);
   endfunction

   // build one random display list into list_bytes
   function automatic void build_list(int nattr);
      int          n;
      int          r;
      int          nv;
      logic [15:0] cnt;
      logic [15:0] idx;
      logic [7:0]  op;
      list_bytes.delete();
      // noise: raw random bytes
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 12);
         repeat (n) add_byte(8'($urandom));
         return;
      end
      n = $urandom_range(1, 3);
      for (int p = 0; p < n; p++) begin
         r = $urandom_range(0, 19);
         if (r < 5)       op = dlpa_pkg::OP_LIST;
         else if (r < 10) op = dlpa_pkg::OP_STRIP;
         else if (r < 15) op = dlpa_pkg::OP_FAN;
         else if (r < 16) op = dlpa_pkg::OP_NOP;
         else             op = 8'($urandom_range(1, 255));
         add_byte(op);
         if (op == dlpa_pkg::OP_NOP) continue;
         if ($urandom_range(0, 15) == 0)      cnt = 16'd0;
         else if ($urandom_range(0, 15) == 0) cnt = 16'($urandom_range(256, 65535));
         else                                 cnt = 16'($urandom_range(1, 7));
         add_byte(cnt[15:8]);
         add_byte(cnt[7:0]);
         nv = (cnt > 16'd9) ? $urandom_range(1, 9) : int'(cnt);
         for (int v = 0; v < nv; v++) begin
            for (int a = 0; a < nattr; a++) begin
               idx = pick_index();
               add_byte(idx[15:8]);
               add_byte(idx[7:0]);
            end
         end
         // a huge count is cut off by the end of the list
         if (int'(cnt) > nv) break;
      end
      // broken list: drop a random tail
      if (list_bytes.size() > 1 && $urandom_range(0, 7) == 0) begin
         r = $urandom_range(1, list_bytes.size() - 1);
         while (list_bytes.size() > r) void'(list_bytes.pop_back());
      end
   endfunction

   initial begin
      int         sent;
      int         waited;
      logic [2:0] attrs;
      tri_model = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: no-op, full list, zero count, fan closing on the last byte
      list_bytes = '{dlpa_pkg::OP_NOP,
                     dlpa_pkg::OP_LIST, 8'h00, 8'h03, 8'hFF, 8'hFF, 8'h00, 8'h00,
                     8'h80, 8'h01,
                     dlpa_pkg::OP_STRIP, 8'h00, 8'h00,
                     dlpa_pkg::OP_FAN, 8'h00, 8'h03, 8'h12, 8'h34, 8'hFF, 8'hFE,
                     8'h00, 8'h01};
      send_list();
      // directed: strip cut off by the end of the list
      list_bytes = '{dlpa_pkg::OP_STRIP, 8'h00, 8'h04, 8'hC3};
      send_list();
      settle();

      // random phases, each under its own attribute count
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0:       attrs = 3'd4;
            1:       attrs = 3'd0;
            2:       attrs = 3'd2;
            3:       attrs = 3'd7;
            4:       attrs = 3'd3;
            5:       attrs = 3'd5;
            6:       attrs = 3'd1;
            7:       attrs = 3'd6;
            default: attrs = 3'($urandom_range(0, 7));
         endcase
         write_attrs(attrs);
         sent = 0;
         while (sent < BYTES_PER_PHASE) begin
            build_list(tri_model.attrs_in_use());
            send_list();
            sent += list_bytes.size();
         end
         settle();
      end

      // drain with a bound, then let any stray triangle show up
      waited = 0;
      while (tri_model.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (tri_model.pending() != 0) begin
         $error("%0d expected triangles never arrived", tri_model.pending());
         tri_model.mismatches++;
      end
      repeat (20) @(posedge clock);
      if (tri_model.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // hard stop if the run hangs
   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

endmodule
